### hw/rtl/tbps_pkg.sv
// shared types and constants of the token bucket packet shaper
`default_nettype none

package tbps_pkg;

  localparam int KIND_W = 3;
  localparam int NUM_W  = 16;
  localparam int TOK_W  = 16;

  // result kinds
  localparam logic [KIND_W-1:0] EV_QUEUED     = 3'd0;
  localparam logic [KIND_W-1:0] EV_TOO_BIG    = 3'd1;
  localparam logic [KIND_W-1:0] EV_FULL       = 3'd2;
  localparam logic [KIND_W-1:0] EV_TOKEN_ADD  = 3'd3;
  localparam logic [KIND_W-1:0] EV_TOKEN_DROP = 3'd4;
  localparam logic [KIND_W-1:0] EV_RELEASE    = 3'd5;

  // input command codes
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // register map (word index)
  localparam logic REG_BUCKET_DEPTH = 1'b0;

  localparam logic [TOK_W-1:0] DEPTH_RST = 16'd10;

  // releases allowed after one arrival and after one tick
  localparam int REL_W = 5;
  localparam logic [REL_W-1:0] REL_LIMIT_ARRIVAL = 5'd16;
  localparam logic [REL_W-1:0] REL_LIMIT_TICK    = 5'd1;

  // controller to datapath
  typedef struct packed {
    logic accept;   // apply the input transaction
    logic rd_head;  // read the queue head entry
    logic pop_head; // release the head packet
    logic emit;     // load the pending result into the output register
    logic last;     // last flag of the emitted result
  } tbps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic too_big;      // arriving packet exceeds bucket depth
    logic can_release;  // head entry is covered and a release is allowed
    logic out_free;     // output register can take a result
  } tbps_stat_t;

endpackage

`default_nettype wire

### hw/rtl/tbps_in_if.sv
// input channel interface: event transactions
`default_nettype none

interface tbps_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [tbps_pkg::TOK_W-1:0]   tokens_needed;

  modport source (output valid, cmd, tokens_needed, input ready);
  modport sink   (input valid, cmd, tokens_needed, output ready);
endinterface

`default_nettype wire

### hw/rtl/tbps_out_if.sv
// result channel interface: shaper event transactions
`default_nettype none

interface tbps_out_if;
  logic                          valid;
  logic                          ready;
  logic [tbps_pkg::KIND_W-1:0]   event_kind;
  logic [tbps_pkg::NUM_W-1:0]    packet_number;
  logic [tbps_pkg::TOK_W-1:0]    tokens_left;
  logic                          last;

  modport source (output valid, event_kind, packet_number, tokens_left, last, input ready);
  modport sink   (input valid, event_kind, packet_number, tokens_left, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/token_bucket_packet_shaper.sv
// top level of the token bucket packet shaper
//
//   port group   direction  carries
//   in_ch        sink       event: cmd, tokens_needed
//   out_ch       source     result: event_kind, packet_number, tokens_left, last
//   psel..pready apb slave  bucket_depth at byte address 0
//
// an input transaction is taken only in the idle state; a tick or an arrival
// does a queue memory read then a check, again for each released packet; a
// too-big arrival goes straight to the finish step; results wait in one output
// register; a stalled result holds the sequencer at its check or finish step
// rst_n is synchronous: token count, queue pointers and packet counter clear,
// bucket_depth returns to 10; the queue memory is not cleared
`default_nettype none

module token_bucket_packet_shaper #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  tbps_in_if.sink      in_ch,
  tbps_out_if.source   out_ch,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  tbps_pkg::tbps_cmd_t  cmd;
  tbps_pkg::tbps_stat_t stat;
  logic                 in_ready;

  // sequencer
  tbps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath
  tbps_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_cmd            (in_ch.cmd),
    .in_tokens_needed  (in_ch.tokens_needed),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_event_kind    (out_ch.event_kind),
    .out_packet_number (out_ch.packet_number),
    .out_tokens_left   (out_ch.tokens_left),
    .out_last          (out_ch.last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // release only when the head entry is covered
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_head |-> stat.can_release)
    else $error("release without cover");

  // a result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result overwritten");

  // input transactions are never taken back to back
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_ready)
    else $error("input taken while busy");

  // a release is always paired with emitting the previous result
  a_release_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_head |-> (cmd.emit && !cmd.last))
    else $error("release without emit");

endmodule

`default_nettype wire

### hw/rtl/tbps_ctrl.sv
// sequencing state machine of the shaper
`default_nettype none

module tbps_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  tbps_pkg::tbps_stat_t stat,
  output tbps_pkg::tbps_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.too_big ? S_FIN : S_READ;
        end
      end
      S_READ: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = !stat.can_release;
          if (stat.can_release) begin
            cmd.pop_head = 1'b1;
            state_nxt    = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tbps_datapath.sv
// token count, packet queue, config register and output register
`default_nettype none

module tbps_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // command and status
  input  tbps_pkg::tbps_cmd_t               cmd,
  output tbps_pkg::tbps_stat_t              stat,
  // input payload
  input  wire                               in_cmd,
  input  wire  [tbps_pkg::TOK_W-1:0]        in_tokens_needed,
  // result side
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [tbps_pkg::KIND_W-1:0]       out_event_kind,
  output logic [tbps_pkg::NUM_W-1:0]        out_packet_number,
  output logic [tbps_pkg::TOK_W-1:0]        out_tokens_left,
  output logic                              out_last,
  // config port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [2:0]                        paddr,
  input  wire  [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = tbps_pkg::NUM_W + tbps_pkg::TOK_W;

  logic [tbps_pkg::TOK_W-1:0]  depth_r;
  logic [tbps_pkg::TOK_W-1:0]  tokens_r;
  logic [PTR_W-1:0]            head_r;
  logic [PTR_W-1:0]            tail_r;
  logic [FILL_W-1:0]           fill_r;
  logic [COUNT_WIDTH-1:0]      arr_cnt_r;
  logic [tbps_pkg::REL_W-1:0]  rel_left_r;
  logic [ENT_W-1:0]            rd_data_r;
  logic [ENT_W-1:0]            mem [QUEUE_DEPTH];

  logic [tbps_pkg::KIND_W-1:0] pend_kind_r;
  logic [tbps_pkg::NUM_W-1:0]  pend_num_r;
  logic [tbps_pkg::TOK_W-1:0]  pend_tok_r;
  logic                        out_valid_r;

  logic [COUNT_WIDTH-1:0]      arr_cnt_nxt;
  logic [31:0]                 arr_ext;
  logic [tbps_pkg::NUM_W-1:0]  new_num;
  logic                        q_full;
  logic                        cfg_wr;
  logic [tbps_pkg::TOK_W-1:0]  head_need;
  logic [tbps_pkg::TOK_W-1:0]  tok_after_rel;

  assign arr_cnt_nxt   = arr_cnt_r + 1'b1;
  assign arr_ext       = 32'(arr_cnt_nxt);
  assign new_num       = arr_ext[tbps_pkg::NUM_W-1:0];
  assign q_full        = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign head_need     = rd_data_r[tbps_pkg::TOK_W-1:0];
  assign tok_after_rel = tokens_r - head_need;

  // status toward the controller
  assign stat.too_big     = (in_cmd == tbps_pkg::CMD_ARRIVAL) && (in_tokens_needed > depth_r);
  assign stat.can_release = (fill_r != '0) && (head_need <= tokens_r) && (rel_left_r != '0);
  assign stat.out_free    = !out_valid_r || out_ready;

  // config register access
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == tbps_pkg::REG_BUCKET_DEPTH);
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == tbps_pkg::REG_BUCKET_DEPTH) begin
      prdata = {16'd0, depth_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= tbps_pkg::DEPTH_RST;
    end else if (cfg_wr) begin
      depth_r <= pwdata[tbps_pkg::TOK_W-1:0];
    end
  end

  // bucket and queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tokens_r  <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      arr_cnt_r <= '0;
    end else if (cmd.accept) begin
      if (in_cmd == tbps_pkg::CMD_ARRIVAL) begin
        arr_cnt_r <= arr_cnt_nxt;
        if (!stat.too_big && !q_full) begin
          tail_r <= (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          fill_r <= fill_r + 1'b1;
        end
      end else if (tokens_r < depth_r) begin
        tokens_r <= tokens_r + 1'b1;
      end
    end else if (cmd.pop_head) begin
      tokens_r <= tok_after_rel;
      head_r   <= (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_r   <= fill_r - 1'b1;
    end
  end

  // pending result and release budget
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_cmd == tbps_pkg::CMD_ARRIVAL) begin
        rel_left_r <= tbps_pkg::REL_LIMIT_ARRIVAL;
        pend_num_r <= new_num;
        pend_tok_r <= tokens_r;
        if (stat.too_big) begin
          pend_kind_r <= tbps_pkg::EV_TOO_BIG;
        end else if (q_full) begin
          pend_kind_r <= tbps_pkg::EV_FULL;
        end else begin
          pend_kind_r <= tbps_pkg::EV_QUEUED;
        end
      end else begin
        rel_left_r <= tbps_pkg::REL_LIMIT_TICK;
        pend_num_r <= '0;
        if (tokens_r < depth_r) begin
          pend_kind_r <= tbps_pkg::EV_TOKEN_ADD;
          pend_tok_r  <= tokens_r + 1'b1;
        end else begin
          pend_kind_r <= tbps_pkg::EV_TOKEN_DROP;
          pend_tok_r  <= tokens_r;
        end
      end
    end else if (cmd.pop_head) begin
      rel_left_r  <= rel_left_r - 1'b1;
      pend_kind_r <= tbps_pkg::EV_RELEASE;
      pend_num_r  <= rd_data_r[ENT_W-1:tbps_pkg::TOK_W];
      pend_tok_r  <= tok_after_rel;
    end
  end

  // packet queue memory
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_cmd == tbps_pkg::CMD_ARRIVAL) && !stat.too_big && !q_full) begin
      mem[tail_r] <= {new_num, in_tokens_needed};
    end
    if (cmd.rd_head) begin
      rd_data_r <= mem[head_r];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_event_kind    <= pend_kind_r;
      out_packet_number <= pend_num_r;
      out_tokens_left   <= pend_tok_r;
      out_last          <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### tb/token_bucket_packet_shaper_tb.sv
// self-checking testbench for the token bucket packet shaper
module token_bucket_packet_shaper_tb;
  import tbps_pkg::*;

  localparam int QDEPTH = 16;
  localparam int COUNT_W = 16;
  localparam int MAX_RES = 17;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int ZERO_DEPTH_ITEMS = 8;
  localparam int RAND_PER_PHASE = 55;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] DEPTH_ADDR = {REG_BUCKET_DEPTH, 2'b00};

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NUM_W-1:0]  num;
    logic [TOK_W-1:0]  tokens;
    logic              last;
  } shaper_result_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [TOK_W-1:0] need;
  } held_pkt_t;

  // predicts the shaper and matches its results in order
  class shaper_scoreboard;
    logic [TOK_W-1:0]   depth;
    logic [TOK_W-1:0]   tokens;
    logic [COUNT_W-1:0] pkt_serial;
    held_pkt_t          held[$];
    shaper_result_t     expected_results[$];
    int unsigned        mismatches;

    function new();
      depth = DEPTH_RST;
      tokens = '0;
      pkt_serial = '0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function void push_result(logic [KIND_W-1:0] kind, logic [NUM_W-1:0] num);
      shaper_result_t r;
      r.kind = kind;
      r.num = num;
      r.tokens = tokens;
      r.last = 1'b0;
      expected_results.push_back(r);
    endfunction

    // release the head packet if the bucket covers it
    function bit release_head();
      held_pkt_t h;
      if (held.size() == 0) return 1'b0;
      h = held[0];
      if (h.need > tokens) return 1'b0;
      tokens -= h.need;
      void'(held.pop_front());
      push_result(EV_RELEASE, h.num);
      return 1'b1;
    endfunction

    // accepted input transaction: work out every result it causes
    function void note_event(logic cmd, logic [TOK_W-1:0] need);
      int n;
      held_pkt_t p;
      if (cmd == CMD_ARRIVAL) begin
        pkt_serial++;
        if (need > depth) begin
          push_result(EV_TOO_BIG, NUM_W'(pkt_serial));
        end else begin
          if (held.size() >= QDEPTH) begin
            push_result(EV_FULL, NUM_W'(pkt_serial));
          end else begin
            p.num = NUM_W'(pkt_serial);
            p.need = need;
            held.push_back(p);
            push_result(EV_QUEUED, NUM_W'(pkt_serial));
          end
          n = 1;
          while (n < MAX_RES && release_head()) n++;
        end
      end else begin
        if (tokens < depth) begin
          tokens++;
          push_result(EV_TOKEN_ADD, '0);
        end else begin
          push_result(EV_TOKEN_DROP, '0);
        end
        void'(release_head());
      end
      expected_results[expected_results.size()-1].last = 1'b1;
    endfunction

    function void check_result(shaper_result_t got);
      shaper_result_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result: kind %0d pkt %0d tokens %0d last %0b",
                       got.kind, got.num, got.tokens, got.last));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.num !== want.num ||
          got.tokens !== want.tokens || got.last !== want.last)
        flag($sformatf({"result mismatch: expected kind %0d pkt %0d tokens %0d last %0b,",
                        " got kind %0d pkt %0d tokens %0d last %0b"},
                       want.kind, want.num, want.tokens, want.last,
                       got.kind, got.num, got.tokens, got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tbps_in_if  in_ch();
  tbps_out_if out_ch();

  shaper_scoreboard sb;
  int unsigned      holds_asked;
  logic             rx_fast;
  int unsigned      cycles;

  token_bucket_packet_shaper #(
    .QUEUE_DEPTH(QDEPTH),
    .COUNT_WIDTH(COUNT_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    shaper_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.event_kind;
      got.num = out_ch.packet_number;
      got.tokens = out_ch.tokens_left;
      got.last = out_ch.last;
      sb.check_result(got);
    end
  end

  // receiver: changing stall pattern, long hold-off on request
  rx_mode_t    rx_mode = RX_ALWAYS;
  int unsigned rx_age = 0;
  int unsigned rx_count = 0;
  int unsigned hold_left = 0;
  int unsigned holds_seen = 0;

  always @(posedge clk) begin
    rx_count++;
    if (holds_seen != holds_asked) begin
      holds_seen = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (rx_age == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_age = $urandom_range(16, 96);
    end else begin
      rx_age--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_fast) begin
      out_ch.ready <= 1'b1;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   out_ch.ready <= 1'b1;
        RX_MOSTLY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_RARELY:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= ((rx_count % 3) == 0);
      endcase
    end
  end

  // offer one event and wait for its handshake; valid stays high
  task automatic send_event(input logic cmd, input logic [TOK_W-1:0] need);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.tokens_needed <= need;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(cmd, need);
  endtask

  task automatic wait_for_results();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write of bucket_depth, then read it back
  task automatic write_depth(input logic [TOK_W-1:0] value);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DEPTH_ADDR;
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.depth = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[TOK_W-1:0] !== value)
      sb.flag($sformatf("bucket_depth readback: expected %0d got %0d",
                        value, readback[TOK_W-1:0]));
  endtask

  // random event, needs kept within reach of the bucket most of the time
  function automatic void pick_event(output logic cmd, output logic [TOK_W-1:0] need);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    need = TOK_W'($urandom);
    cmd = CMD_ARRIVAL;
    if (roll < 50) cmd = CMD_TICK;
    else if (sb.depth > 16'd1000) need = TOK_W'($urandom_range(0, 8));
    else if (roll < 60) need = '0;
    else if (roll < 88) need = TOK_W'($urandom_range(0, sb.depth));
  endfunction

  // bursts of random events with random gaps, now and then a full drain
  task automatic run_random(input int count);
    int sent;
    int burst;
    int gap;
    logic cmd;
    logic [TOK_W-1:0] need;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < count) begin
        pick_event(cmd, need);
        send_event(cmd, need);
        sent++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) begin
        in_ch.valid <= 1'b0;
        wait_for_results();
      end else if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("token_bucket_packet_shaper_tb: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ARRIVAL;
    in_ch.tokens_needed = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    holds_asked = 0;
    rx_fast = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset depth: zero need, too big, full queue, blocked head, longest release run
    send_event(CMD_ARRIVAL, 16'd0);
    send_event(CMD_ARRIVAL, 16'hFFFF);
    send_event(CMD_ARRIVAL, 16'd3);
    repeat (16) send_event(CMD_ARRIVAL, 16'd0);
    repeat (3) send_event(CMD_TICK, TOK_W'($urandom));
    send_event(CMD_ARRIVAL, 16'd0);
    in_ch.valid <= 1'b0;
    wait_for_results();

    // full bucket drops a token, then depth lowered below the count
    write_depth(16'd2);
    repeat (3) send_event(CMD_TICK, TOK_W'($urandom));
    in_ch.valid <= 1'b0;
    wait_for_results();
    write_depth(16'd1);
    send_event(CMD_TICK, TOK_W'($urandom));
    send_event(CMD_ARRIVAL, 16'd2);
    send_event(CMD_ARRIVAL, 16'd1);
    in_ch.valid <= 1'b0;
    wait_for_results();

    // zero depth, back to back arrivals that are all too big
    write_depth('0);
    rx_fast <= 1'b1;
    repeat (ZERO_DEPTH_ITEMS) send_event(CMD_ARRIVAL, TOK_W'($urandom_range(1, 65535)));
    in_ch.valid <= 1'b0;
    rx_fast <= 1'b0;
    wait_for_results();

    // random traffic under several depths; the first phase starts with a long hold-off
    write_depth(TOK_W'($urandom_range(1, 15)));
    holds_asked <= holds_asked + 1;
    run_random(RAND_PER_PHASE);
    wait_for_results();
    write_depth(16'hFFFF);
    run_random(RAND_PER_PHASE);
    wait_for_results();
    write_depth(TOK_W'($urandom_range(8, 15)));
    run_random(RAND_PER_PHASE);
    wait_for_results();
    write_depth('0);
    run_random(RAND_PER_PHASE);
    wait_for_results();

    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("token_bucket_packet_shaper_tb: PASS");
    end else begin
      $display("token_bucket_packet_shaper_tb: FAIL");
    end
    $finish;
  end

endmodule
